// ----- src/sensor_average_and_report_filter_macros.svh -----
// Assertion macros used by the checker file of the report filter.
`ifndef SENSOR_AVERAGE_AND_REPORT_FILTER_MACROS_SVH
`define SENSOR_AVERAGE_AND_REPORT_FILTER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SARF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent in the following cycle.
`define SARF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- src/sarf_pkg.sv -----
// Types, constants and arithmetic helpers of the sensor report filter.
package sarf_pkg;

   localparam int WINDOW          = 5;
   localparam int HEARTBEAT_LIMIT = 30;
   localparam int QUEUE_DEPTH     = 2;

   localparam int PTR_W   = $clog2(WINDOW);
   localparam int QUIET_W = $clog2(HEARTBEAT_LIMIT + 2);

   localparam logic [15:0] DELTA_LUX  = 16'd5;
   localparam logic [15:0] DELTA_HUMI = 16'd1;
   localparam logic [15:0] DELTA_TEMP = 16'd1;
   localparam logic [15:0] DELTA_BAT  = 16'd1;

   localparam logic [7:0]  BAT_RING_RESET = 8'd100;
   localparam logic [15:0] HUM_RING_RESET = 16'd75;
   localparam logic [15:0] TMP_RING_RESET = 16'd25;

   localparam logic [15:0] BAT_SUM_RESET = 16'(WINDOW * 100);
   localparam logic [15:0] HUM_SUM_RESET = 16'(WINDOW * 75);
   localparam logic [15:0] TMP_SUM_RESET = 16'(WINDOW * 25);

   // Exact x / WINDOW for 16-bit x by reciprocal multiply.
   localparam int DIV_SHIFT = 16 + $clog2(WINDOW);
   localparam logic [DIV_SHIFT-1:0] DIV_RECIP =
      DIV_SHIFT'(((2 ** DIV_SHIFT) + WINDOW - 1) / WINDOW);

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_BATTERY_MIN     = 3'd0;
   localparam logic [2:0] REG_BATTERY_MAX     = 3'd1;
   localparam logic [2:0] REG_HUMIDITY_MIN    = 3'd2;
   localparam logic [2:0] REG_HUMIDITY_MAX    = 3'd3;
   localparam logic [2:0] REG_TEMPERATURE_MIN = 3'd4;
   localparam logic [2:0] REG_TEMPERATURE_MAX = 3'd5;
   localparam logic [2:0] REG_LUX_MIN         = 3'd6;
   localparam logic [2:0] REG_LUX_MAX         = 3'd7;

   typedef struct packed {
      logic [7:0]  battery_min;
      logic [7:0]  battery_max;
      logic [15:0] humidity_min;
      logic [15:0] humidity_max;
      logic [15:0] temperature_min;
      logic [15:0] temperature_max;
      logic [15:0] lux_min;
      logic [15:0] lux_max;
   } cfg_type;

   // One round with its window sums on its way from front to back.
   typedef struct packed {
      logic [15:0] sum_battery;
      logic [15:0] sum_humidity;
      logic [15:0] sum_temperature;
      logic [15:0] lux;
      logic        motion;
      logic        force_rpt;
   } round_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [15:0] div_window(input logic [15:0] x);
      logic [16+DIV_SHIFT-1:0] prod;
      prod = {{DIV_SHIFT{1'b0}}, x} * {16'd0, DIV_RECIP};
      return prod[16+DIV_SHIFT-1 -: 16];
   endfunction

   function automatic logic [15:0] clamp16(input logic [15:0] v,
                                           input logic [15:0] lo,
                                           input logic [15:0] hi);
      logic [15:0] r;
      r = v;
      if (r < lo) begin
         r = lo;
      end
      if (r > hi) begin
         r = hi;
      end
      return r;
   endfunction

   function automatic logic [15:0] absdiff16(input logic [15:0] a,
                                             input logic [15:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

// ----- src/sarf_front.sv -----
// Front end: ring write, running window sums, hand-off to the queue.
module sarf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           battery_pct,
   input  logic [15:0]          humidity,
   input  logic [15:0]          temperature,
   input  logic [15:0]          lux,
   input  logic                 motion_changed,
   input  logic                 force_report,
   output sarf_pkg::round_type  push_data
);

   logic [7:0]  bat_ring_ff [sarf_pkg::WINDOW];
   logic [15:0] hum_ring_ff [sarf_pkg::WINDOW];
   logic [15:0] tmp_ring_ff [sarf_pkg::WINDOW];
   logic [sarf_pkg::PTR_W-1:0] pos_ff, pos_in;
   logic [15:0] bat_sum_ff, bat_sum_in;
   logic [15:0] hum_sum_ff, hum_sum_in;
   logic [15:0] tmp_sum_ff, tmp_sum_in;

   // Drop the oldest entry, add the new sample; wrapping matches a full re-sum.
   always_comb begin
      bat_sum_in = bat_sum_ff - {8'd0, bat_ring_ff[pos_ff]} + {8'd0, battery_pct};
      hum_sum_in = hum_sum_ff - hum_ring_ff[pos_ff] + humidity;
      tmp_sum_in = tmp_sum_ff - tmp_ring_ff[pos_ff] + temperature;
      if (pos_ff == sarf_pkg::PTR_W'(sarf_pkg::WINDOW - 1)) begin
         pos_in = '0;
      end else begin
         pos_in = pos_ff + 1'b1;
      end
      push_data.sum_battery     = bat_sum_in;
      push_data.sum_humidity    = hum_sum_in;
      push_data.sum_temperature = tmp_sum_in;
      push_data.lux             = lux;
      push_data.motion          = motion_changed;
      push_data.force_rpt       = force_report;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sarf_pkg::WINDOW; i++) begin
            bat_ring_ff[i] <= sarf_pkg::BAT_RING_RESET;
            hum_ring_ff[i] <= sarf_pkg::HUM_RING_RESET;
            tmp_ring_ff[i] <= sarf_pkg::TMP_RING_RESET;
         end
         pos_ff     <= '0;
         bat_sum_ff <= sarf_pkg::BAT_SUM_RESET;
         hum_sum_ff <= sarf_pkg::HUM_SUM_RESET;
         tmp_sum_ff <= sarf_pkg::TMP_SUM_RESET;
      end else if (accept) begin
         bat_ring_ff[pos_ff] <= battery_pct;
         hum_ring_ff[pos_ff] <= humidity;
         tmp_ring_ff[pos_ff] <= temperature;
         pos_ff     <= pos_in;
         bat_sum_ff <= bat_sum_in;
         hum_sum_ff <= hum_sum_in;
         tmp_sum_ff <= tmp_sum_in;
      end
   end

endmodule

// ----- src/sarf_queue.sv -----
// Short queue of summed rounds between the front and back ends.
module sarf_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  sarf_pkg::round_type           push_data,
   input  logic                          pop,
   output sarf_pkg::round_type           head,
   output sarf_pkg::queue_status_type    status
);

   localparam int AW = $clog2(sarf_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(sarf_pkg::QUEUE_DEPTH + 1);

   sarf_pkg::round_type slot_ff [sarf_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      status.full  = (count_ff == CW'(sarf_pkg::QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      head         = slot_ff[rd_ptr_ff];
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(sarf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(sarf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/sarf_back.sv -----
// Back end: average, clamp, send-on-delta decision and result register.
module sarf_back (
   input  logic                        clock,
   input  logic                        reset,
   input  sarf_pkg::cfg_type           cfg,
   input  sarf_pkg::round_type         head,
   input  sarf_pkg::queue_status_type  qstat,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_avg_battery,
   output logic [15:0]                 rsp_avg_humidity,
   output logic [15:0]                 rsp_avg_temperature,
   output logic [15:0]                 rsp_clamped_lux,
   output logic                        rsp_report_lux,
   output logic                        rsp_report_temperature,
   output logic                        rsp_report_humidity,
   output logic                        rsp_report_battery,
   output logic                        rsp_report_motion
);

   localparam int QW = sarf_pkg::QUIET_W;
   localparam logic [QW-1:0] LIMIT = QW'(sarf_pkg::HEARTBEAT_LIMIT);

   logic        valid_ff;
   logic [7:0]  avg_bat_ff;
   logic [15:0] avg_hum_ff, avg_tmp_ff, lux_ff;
   logic        rl_ff, rt_ff, rh_ff, rb_ff, rm_ff;
   logic        rl_in, rt_in, rh_in, rb_in, rm_in;

   logic [15:0] sent_lux_ff, sent_lux_in;
   logic [15:0] sent_tmp_ff, sent_tmp_in;
   logic [15:0] sent_hum_ff, sent_hum_in;
   logic [7:0]  sent_bat_ff, sent_bat_in;
   logic [QW-1:0] q_lux_ff, q_tmp_ff, q_hum_ff, q_bat_ff, q_mot_ff;
   logic [QW-1:0] q_lux_in, q_tmp_in, q_hum_in, q_bat_in, q_mot_in;

   logic [15:0] quot_bat;
   logic [15:0] ab_wide;
   logic [7:0]  ab;
   logic [15:0] ah, at, lx;
   logic        mv_lux, mv_tmp, mv_hum, mv_bat;

   always_comb begin
      pop = !qstat.empty && (!valid_ff || !rsp_stall);

      quot_bat = sarf_pkg::div_window(head.sum_battery);
      ab_wide  = sarf_pkg::clamp16({8'd0, quot_bat[7:0]},
                                   {8'd0, cfg.battery_min}, {8'd0, cfg.battery_max});
      ab       = ab_wide[7:0];
      ah = sarf_pkg::clamp16(sarf_pkg::div_window(head.sum_humidity),
                             cfg.humidity_min, cfg.humidity_max);
      at = sarf_pkg::clamp16(sarf_pkg::div_window(head.sum_temperature),
                             cfg.temperature_min, cfg.temperature_max);
      lx = sarf_pkg::clamp16(head.lux, cfg.lux_min, cfg.lux_max);

      mv_lux = sarf_pkg::absdiff16(lx, sent_lux_ff) > sarf_pkg::DELTA_LUX;
      mv_tmp = sarf_pkg::absdiff16(at, sent_tmp_ff) > sarf_pkg::DELTA_TEMP;
      mv_hum = sarf_pkg::absdiff16(ah, sent_hum_ff) > sarf_pkg::DELTA_HUMI;
      mv_bat = sarf_pkg::absdiff16({8'd0, ab}, {8'd0, sent_bat_ff}) > sarf_pkg::DELTA_BAT;

      q_lux_in = q_lux_ff;
      q_tmp_in = q_tmp_ff;
      q_hum_in = q_hum_ff;
      q_bat_in = q_bat_ff;

      if (head.motion) begin
         // Motion wins: report it, lux only on delta, leave other counters alone.
         rm_in    = 1'b1;
         q_mot_in = '0;
         rl_in    = mv_lux;
         rt_in    = 1'b0;
         rh_in    = 1'b0;
         rb_in    = 1'b0;
      end else begin
         rl_in    = mv_lux || (q_lux_ff > LIMIT) || head.force_rpt;
         rt_in    = mv_tmp || (q_tmp_ff > LIMIT) || head.force_rpt;
         rh_in    = mv_hum || (q_hum_ff > LIMIT) || head.force_rpt;
         rb_in    = mv_bat || (q_bat_ff > LIMIT) || head.force_rpt;
         rm_in    = (q_mot_ff > LIMIT) || head.force_rpt;
         q_lux_in = rl_in ? '0 : q_lux_ff + 1'b1;
         q_tmp_in = rt_in ? '0 : q_tmp_ff + 1'b1;
         q_hum_in = rh_in ? '0 : q_hum_ff + 1'b1;
         q_bat_in = rb_in ? '0 : q_bat_ff + 1'b1;
         q_mot_in = rm_in ? '0 : q_mot_ff + 1'b1;
      end

      sent_lux_in = rl_in ? lx : sent_lux_ff;
      sent_tmp_in = rt_in ? at : sent_tmp_ff;
      sent_hum_in = rh_in ? ah : sent_hum_ff;
      sent_bat_in = rb_in ? ab : sent_bat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         sent_lux_ff <= '0;
         sent_tmp_ff <= '0;
         sent_hum_ff <= '0;
         sent_bat_ff <= '0;
         q_lux_ff    <= '0;
         q_tmp_ff    <= '0;
         q_hum_ff    <= '0;
         q_bat_ff    <= '0;
         q_mot_ff    <= '0;
      end else begin
         if (pop) begin
            valid_ff    <= 1'b1;
            sent_lux_ff <= sent_lux_in;
            sent_tmp_ff <= sent_tmp_in;
            sent_hum_ff <= sent_hum_in;
            sent_bat_ff <= sent_bat_in;
            q_lux_ff    <= q_lux_in;
            q_tmp_ff    <= q_tmp_in;
            q_hum_ff    <= q_hum_in;
            q_bat_ff    <= q_bat_in;
            q_mot_ff    <= q_mot_in;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         avg_bat_ff <= ab;
         avg_hum_ff <= ah;
         avg_tmp_ff <= at;
         lux_ff     <= lx;
         rl_ff      <= rl_in;
         rt_ff      <= rt_in;
         rh_ff      <= rh_in;
         rb_ff      <= rb_in;
         rm_ff      <= rm_in;
      end
   end

   assign rsp_valid              = valid_ff;
   assign rsp_avg_battery        = avg_bat_ff;
   assign rsp_avg_humidity       = avg_hum_ff;
   assign rsp_avg_temperature    = avg_tmp_ff;
   assign rsp_clamped_lux        = lux_ff;
   assign rsp_report_lux         = rl_ff;
   assign rsp_report_temperature = rt_ff;
   assign rsp_report_humidity    = rh_ff;
   assign rsp_report_battery     = rb_ff;
   assign rsp_report_motion      = rm_ff;

endmodule

// ----- src/sensor_average_and_report_filter.sv -----
// Top level of the sensor moving-average and send-on-delta report filter.
// An accepted item is written into a queue slot and from there into the result
// register, which drives the rsp_ ports.
// Throughput: one item per cycle unless the queue is full; a two-item queue
// parts the front sum update from the back divide, clamp and report decision.
// Reset (synchronous, active high) refills the rings, clears the last-sent
// values, quiet counters and queue, and loads the register defaults.
module sensor_average_and_report_filter (
   input  logic        clock,
   input  logic        reset,
   // measurement rounds
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_battery_pct,
   input  logic [15:0] req_humidity,
   input  logic [15:0] req_temperature,
   input  logic [15:0] req_lux,
   input  logic        req_motion_changed,
   input  logic        req_force_report,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_avg_battery,
   output logic [15:0] rsp_avg_humidity,
   output logic [15:0] rsp_avg_temperature,
   output logic [15:0] rsp_clamped_lux,
   output logic        rsp_report_lux,
   output logic        rsp_report_temperature,
   output logic        rsp_report_humidity,
   output logic        rsp_report_battery,
   output logic        rsp_report_motion,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   sarf_pkg::cfg_type           cfg_ff, cfg_in;
   sarf_pkg::round_type         push_data;
   sarf_pkg::round_type         head;
   sarf_pkg::queue_status_type  qstat;
   logic                        accept;
   logic                        pop;

   // Hold the front while the queue is full; the back drains it on its own.
   assign req_stall = qstat.full;
   assign accept    = req_valid && !req_stall;

   // Registers are always writable; writes are expected only while idle.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            sarf_pkg::REG_BATTERY_MIN:     cfg_in.battery_min     = csr_data[7:0];
            sarf_pkg::REG_BATTERY_MAX:     cfg_in.battery_max     = csr_data[7:0];
            sarf_pkg::REG_HUMIDITY_MIN:    cfg_in.humidity_min    = csr_data;
            sarf_pkg::REG_HUMIDITY_MAX:    cfg_in.humidity_max    = csr_data;
            sarf_pkg::REG_TEMPERATURE_MIN: cfg_in.temperature_min = csr_data;
            sarf_pkg::REG_TEMPERATURE_MAX: cfg_in.temperature_max = csr_data;
            sarf_pkg::REG_LUX_MIN:         cfg_in.lux_min         = csr_data;
            sarf_pkg::REG_LUX_MAX:         cfg_in.lux_max         = csr_data;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.battery_min     <= 8'd0;
         cfg_ff.battery_max     <= 8'd100;
         cfg_ff.humidity_min    <= 16'd0;
         cfg_ff.humidity_max    <= 16'd100;
         cfg_ff.temperature_min <= 16'd0;
         cfg_ff.temperature_max <= 16'd100;
         cfg_ff.lux_min         <= 16'd0;
         cfg_ff.lux_max         <= 16'hFFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: advance the rings and window sums for every accepted item.
   sarf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .battery_pct    (req_battery_pct),
      .humidity       (req_humidity),
      .temperature    (req_temperature),
      .lux            (req_lux),
      .motion_changed (req_motion_changed),
      .force_report   (req_force_report),
      .push_data      (push_data)
   );

   // Queue: part the two ends so each may stall on its own.
   sarf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (qstat)
   );

   // Back: averages, clamps and report flags into the result register.
   sarf_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .cfg                    (cfg_ff),
      .head                   (head),
      .qstat                  (qstat),
      .pop                    (pop),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_avg_battery        (rsp_avg_battery),
      .rsp_avg_humidity       (rsp_avg_humidity),
      .rsp_avg_temperature    (rsp_avg_temperature),
      .rsp_clamped_lux        (rsp_clamped_lux),
      .rsp_report_lux         (rsp_report_lux),
      .rsp_report_temperature (rsp_report_temperature),
      .rsp_report_humidity    (rsp_report_humidity),
      .rsp_report_battery     (rsp_report_battery),
      .rsp_report_motion      (rsp_report_motion)
   );

endmodule

// ----- src/sarf_checker.sv -----
// Port-level checker of the report filter and its bind to the top level.
`include "sensor_average_and_report_filter_macros.svh"

module sarf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_avg_battery,
   input logic [15:0] rsp_clamped_lux
);

   // Reset empties the result register.
   `SARF_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // A fresh result traces back to an accepted item, through the queue and the result register.
   `SARF_ASSERT_SAME(a_latency, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall, 2))

   // A stalled result holds.
   `SARF_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_avg_battery) && $stable(rsp_clamped_lux))

   // A result leaves only once taken.
   `SARF_ASSERT_SAME(a_drop_taken, clock, reset, $fell(rsp_valid), $past(!rsp_stall))

endmodule

bind sensor_average_and_report_filter sarf_checker u_sarf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_avg_battery (rsp_avg_battery),
   .rsp_clamped_lux (rsp_clamped_lux)
);

// ----- dv/sensor_average_and_report_filter_tb.sv -----
// Self-checking testbench for the sensor moving-average and send-on-delta report filter.
`timescale 1ns / 100ps

module sensor_average_and_report_filter_tb;

   localparam int DIRECTED_ROWS = 22;
   localparam int PHASE_ROUNDS  = 305;
   localparam int PHASE_COUNT   = 6;
   localparam int PRESSURE_AT   = 700;  // rounds accepted before the long receiver hold
   localparam int PRESSURE_HOLD = 80;
   localparam int DRAIN_CYCLES  = 8;    // latency through the queue and result register, plus margin
   localparam int STALL_LIMIT   = 2000; // cycles with no handshake anywhere

   typedef enum int {
      CH_LUX    = 0,
      CH_TEMP   = 1,
      CH_HUMI   = 2,
      CH_BAT    = 3,
      CH_MOTION = 4
   } channel_type;

   // One measurement round as offered on the request side.
   typedef struct packed {
      logic [7:0]  battery;
      logic [15:0] humidity;
      logic [15:0] temperature;
      logic [15:0] lux;
      logic        motion;
      logic        forced;
   } stim_type;

   // One result item as it should appear on the response side.
   typedef struct packed {
      logic [7:0]  battery;
      logic [15:0] humidity;
      logic [15:0] temperature;
      logic [15:0] lux;
      logic        rep_lux;
      logic        rep_temp;
      logic        rep_humi;
      logic        rep_bat;
      logic        rep_motion;
   } report_type;

   typedef struct packed {
      stim_type   stim;
      logic       typed;
      report_type want;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_battery_pct;
   logic [15:0] req_humidity;
   logic [15:0] req_temperature;
   logic [15:0] req_lux;
   logic        req_motion_changed;
   logic        req_force_report;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_avg_battery;
   logic [15:0] rsp_avg_humidity;
   logic [15:0] rsp_avg_temperature;
   logic [15:0] rsp_clamped_lux;
   logic        rsp_report_lux;
   logic        rsp_report_temperature;
   logic        rsp_report_humidity;
   logic        rsp_report_battery;
   logic        rsp_report_motion;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   sensor_average_and_report_filter dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_battery_pct        (req_battery_pct),
      .req_humidity           (req_humidity),
      .req_temperature        (req_temperature),
      .req_lux                (req_lux),
      .req_motion_changed     (req_motion_changed),
      .req_force_report       (req_force_report),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_avg_battery        (rsp_avg_battery),
      .rsp_avg_humidity       (rsp_avg_humidity),
      .rsp_avg_temperature    (rsp_avg_temperature),
      .rsp_clamped_lux        (rsp_clamped_lux),
      .rsp_report_lux         (rsp_report_lux),
      .rsp_report_temperature (rsp_report_temperature),
      .rsp_report_humidity    (rsp_report_humidity),
      .rsp_report_battery     (rsp_report_battery),
      .rsp_report_motion      (rsp_report_motion),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   // ------------------------------------------------------------------
   // Filter state mirrored by the testbench
   // ------------------------------------------------------------------
   sarf_pkg::cfg_type limits;
   logic [7:0]  bat_ring [sarf_pkg::WINDOW];
   logic [15:0] hum_ring [sarf_pkg::WINDOW];
   logic [15:0] tmp_ring [sarf_pkg::WINDOW];
   int          ring_slot;
   logic [15:0] sent_lux;
   logic [15:0] sent_temp;
   logic [15:0] sent_humi;
   logic [7:0]  sent_bat;
   logic [7:0]  quiet_count [5];

   report_type  pending_reports [$];   // outstanding result items, oldest first
   report_type  oldest_report;
   int          failures;
   int          rounds_accepted;
   int          results_checked;
   int          settings_applied;
   int          reports_seen [5];
   int          quiet_cycles;
   int          tx_calm;
   int          rx_calm;
   int          rx_stall_left;
   int          rx_open_left;
   bit          pressure_done;

   // Directed rounds, all at reset register values. Only the first three rows
   // carry a typed-in result: reset rings, a forced round and a bare motion round.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{8'd100, 16'd75, 16'd25, 16'd0, 1'b0, 1'b0}, 1'b1,
        '{8'd100, 16'd75, 16'd25, 16'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0}},
      '{'{8'd100, 16'd75, 16'd25, 16'd0, 1'b0, 1'b1}, 1'b1,
        '{8'd100, 16'd75, 16'd25, 16'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}},
      '{'{8'd100, 16'd75, 16'd25, 16'd0, 1'b1, 1'b0}, 1'b1,
        '{8'd100, 16'd75, 16'd25, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
      // lux moves by exactly the delta, then by one more
      '{'{8'd100, 16'd75, 16'd25, 16'd5, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'd100, 16'd75, 16'd25, 16'd6, 1'b0, 1'b0}, 1'b0, '0},
      // all-ones fill: humidity and temperature sums wrap
      '{'{8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1}, 1'b0, '0},
      '{'{8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1}, 1'b0, '0},
      // all-zero fill, opened by a motion round with a large lux step
      '{'{8'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1}, 1'b0, '0},
      '{'{8'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1}, 1'b0, '0},
      // alternating bit patterns
      '{'{8'h55, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b1, 1'b0}, 1'b0, '0},
      // small steps around the deltas
      '{'{8'd1, 16'd1, 16'd1, 16'd3, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'd2, 16'd2, 16'd2, 16'd9, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'd3, 16'd3, 16'd3, 16'd15, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'd100, 16'd101, 16'd102, 16'd65530, 1'b0, 1'b0}, 1'b0, '0}
   };

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic void reset_filter_state();
      limits = '{8'd0, 8'd100, 16'd0, 16'd100, 16'd0, 16'd100, 16'd0, 16'hFFFF};
      for (int i = 0; i < sarf_pkg::WINDOW; i++) begin
         bat_ring[i] = sarf_pkg::BAT_RING_RESET;
         hum_ring[i] = sarf_pkg::HUM_RING_RESET;
         tmp_ring[i] = sarf_pkg::TMP_RING_RESET;
      end
      ring_slot = 0;
      sent_lux  = '0;
      sent_temp = '0;
      sent_humi = '0;
      sent_bat  = '0;
      for (int k = 0; k < 5; k++) begin
         quiet_count[k] = '0;
      end
   endfunction

   // Lower bound first, upper second: crossed bounds give the upper one.
   function automatic logic [15:0] bound(input logic [15:0] v, input logic [15:0] lo,
                                         input logic [15:0] hi);
      logic [15:0] r;
      r = v;
      if (r < lo) begin
         r = lo;
      end
      if (r > hi) begin
         r = hi;
      end
      return r;
   endfunction

   function automatic logic [15:0] gap_between(input logic [15:0] a, input logic [15:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Send-on-delta with heartbeat and force; the quiet count saturates.
   function automatic logic decide(input channel_type ch, input logic moved,
                                   input logic forced);
      if (moved || quiet_count[ch] > sarf_pkg::HEARTBEAT_LIMIT || forced) begin
         quiet_count[ch] = '0;
         return 1'b1;
      end
      if (quiet_count[ch] != 8'hFF) begin
         quiet_count[ch]++;
      end
      return 1'b0;
   endfunction

   function automatic report_type predict_round(input stim_type r);
      logic [15:0] sum_b;
      logic [15:0] sum_h;
      logic [15:0] sum_t;
      logic [7:0]  quot_b;
      report_type  o;
      bat_ring[ring_slot] = r.battery;
      hum_ring[ring_slot] = r.humidity;
      tmp_ring[ring_slot] = r.temperature;
      ring_slot = (ring_slot + 1) % sarf_pkg::WINDOW;
      sum_b = '0;
      sum_h = '0;
      sum_t = '0;
      for (int i = 0; i < sarf_pkg::WINDOW; i++) begin
         sum_b = sum_b + 16'(bat_ring[i]);
         sum_h = sum_h + hum_ring[i];
         sum_t = sum_t + tmp_ring[i];
      end
      // battery quotient is cut to eight bits ahead of its clamp
      quot_b        = 8'(sum_b / sarf_pkg::WINDOW);
      o             = '0;
      o.battery     = 8'(bound({8'd0, quot_b}, {8'd0, limits.battery_min},
                               {8'd0, limits.battery_max}));
      o.humidity    = bound(16'(sum_h / sarf_pkg::WINDOW), limits.humidity_min,
                            limits.humidity_max);
      o.temperature = bound(16'(sum_t / sarf_pkg::WINDOW), limits.temperature_min,
                            limits.temperature_max);
      o.lux         = bound(r.lux, limits.lux_min, limits.lux_max);
      if (r.motion) begin
         // motion wins: only lux may ride along, on delta alone
         quiet_count[CH_MOTION] = '0;
         o.rep_motion = 1'b1;
         if (gap_between(o.lux, sent_lux) > sarf_pkg::DELTA_LUX) begin
            o.rep_lux = 1'b1;
            sent_lux  = o.lux;
         end
      end else begin
         o.rep_lux = decide(CH_LUX, gap_between(o.lux, sent_lux) > sarf_pkg::DELTA_LUX,
                            r.forced);
         if (o.rep_lux) begin
            sent_lux = o.lux;
         end
         o.rep_temp = decide(CH_TEMP,
                             gap_between(o.temperature, sent_temp) > sarf_pkg::DELTA_TEMP,
                             r.forced);
         if (o.rep_temp) begin
            sent_temp = o.temperature;
         end
         o.rep_humi = decide(CH_HUMI,
                             gap_between(o.humidity, sent_humi) > sarf_pkg::DELTA_HUMI,
                             r.forced);
         if (o.rep_humi) begin
            sent_humi = o.humidity;
         end
         o.rep_bat = decide(CH_BAT,
                            gap_between({8'd0, o.battery}, {8'd0, sent_bat})
                               > sarf_pkg::DELTA_BAT,
                            r.forced);
         if (o.rep_bat) begin
            sent_bat = o.battery;
         end
         o.rep_motion = decide(CH_MOTION, 1'b0, r.forced);
      end
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   // Mostly no gap, some short, a few long; now and then a calm stretch.
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(30, 120);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic stim_type random_round();
      stim_type r;
      r.battery     = 8'($urandom);
      r.humidity    = 16'($urandom);
      r.temperature = 16'($urandom);
      r.lux         = 16'($urandom);
      r.motion      = 1'($urandom_range(0, 1));
      r.forced      = 1'($urandom_range(0, 3) == 0);
      return r;
   endfunction

   // Register settings, one per phase: wide open, narrow, crossed, pinned,
   // random, and back to the reset values.
   function automatic sarf_pkg::cfg_type setting_for(input int phase);
      sarf_pkg::cfg_type s;
      case (phase)
         0: s = '{8'd0, 8'd255, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF};
         1: s = '{8'd20, 8'd80, 16'd30, 16'd70, 16'd10, 16'd40, 16'd100, 16'd1000};
         2: s = '{8'd200, 8'd50, 16'd60000, 16'd1000, 16'd5000, 16'd4000, 16'hFFFF, 16'd0};
         3: s = '{8'd255, 8'd255, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0};
         5: s = '{8'd0, 8'd100, 16'd0, 16'd100, 16'd0, 16'd100, 16'd0, 16'hFFFF};
         default: begin
            s.battery_min     = 8'($urandom);
            s.battery_max     = 8'($urandom);
            s.humidity_min    = 16'($urandom);
            s.humidity_max    = 16'($urandom);
            s.temperature_min = 16'($urandom);
            s.temperature_max = 16'($urandom);
            s.lux_min         = 16'($urandom);
            s.lux_max         = 16'($urandom);
         end
      endcase
      return s;
   endfunction

   // Offer one round, hold it until taken, then record its expected result.
   task automatic send_round(input stim_type r, input logic typed, input report_type want);
      int         gap;
      logic       took;
      report_type predicted;
      gap = pick_gap(tx_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_battery_pct    <= r.battery;
      req_humidity       <= r.humidity;
      req_temperature    <= r.temperature;
      req_lux            <= r.lux;
      req_motion_changed <= r.motion;
      req_force_report   <= r.forced;
      // stall is steady from the falling edge to the next rising edge
      do begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
      end while (!took);
      predicted = predict_round(r);
      pending_reports.push_back(typed ? want : predicted);
      rounds_accepted++;
   endtask

   task automatic write_register(input logic [2:0] index, input logic [15:0] data);
      logic took;
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do begin
         @(negedge clock);
         took = csr_ready;
         @(posedge clock);
      end while (!took);
      case (index)
         sarf_pkg::REG_BATTERY_MIN:     limits.battery_min     = data[7:0];
         sarf_pkg::REG_BATTERY_MAX:     limits.battery_max     = data[7:0];
         sarf_pkg::REG_HUMIDITY_MIN:    limits.humidity_min    = data;
         sarf_pkg::REG_HUMIDITY_MAX:    limits.humidity_max    = data;
         sarf_pkg::REG_TEMPERATURE_MIN: limits.temperature_min = data;
         sarf_pkg::REG_TEMPERATURE_MAX: limits.temperature_max = data;
         sarf_pkg::REG_LUX_MIN:         limits.lux_min         = data;
         sarf_pkg::REG_LUX_MAX:         limits.lux_max         = data;
         default: ;
      endcase
   endtask

   // Junk in the upper byte of the battery registers checks their truncation.
   task automatic program_setting(input sarf_pkg::cfg_type s);
      write_register(sarf_pkg::REG_BATTERY_MIN, {8'($urandom), s.battery_min});
      write_register(sarf_pkg::REG_BATTERY_MAX, {8'($urandom), s.battery_max});
      write_register(sarf_pkg::REG_HUMIDITY_MIN, s.humidity_min);
      write_register(sarf_pkg::REG_HUMIDITY_MAX, s.humidity_max);
      write_register(sarf_pkg::REG_TEMPERATURE_MIN, s.temperature_min);
      write_register(sarf_pkg::REG_TEMPERATURE_MAX, s.temperature_max);
      write_register(sarf_pkg::REG_LUX_MIN, s.lux_min);
      write_register(sarf_pkg::REG_LUX_MAX, s.lux_max);
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // Drop valid and let the block drain before touching the registers.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mostly steady runs with small jitter, some jumping halfway, so that averages
   // settle and the quiet counters reach the heartbeat; the rest is noise.
   task automatic run_random(input int count);
      stim_type base;
      stim_type r;
      int       kind;
      int       run_len;
      int       left;
      left = count;
      while (left > 0) begin
         kind    = $urandom_range(0, 9);
         run_len = (kind < 7) ? $urandom_range(20, 70) : $urandom_range(1, 10);
         if (run_len > left) begin
            run_len = left;
         end
         base = random_round();
         if ($urandom_range(0, 1) == 1) begin
            base.battery     = 8'($urandom_range(0, 120));
            base.humidity    = 16'($urandom_range(0, 300));
            base.temperature = 16'($urandom_range(0, 300));
            base.lux         = 16'($urandom_range(0, 2000));
         end
         for (int i = 0; i < run_len; i++) begin
            if (kind < 7) begin
               r = base;
               if ($urandom_range(0, 3) == 0) begin
                  r.battery     = r.battery + 8'($urandom_range(0, 2)) - 8'd1;
                  r.humidity    = r.humidity + 16'($urandom_range(0, 4)) - 16'd2;
                  r.temperature = r.temperature + 16'($urandom_range(0, 4)) - 16'd2;
                  r.lux         = r.lux + 16'($urandom_range(0, 14)) - 16'd7;
               end
               r.motion = 1'($urandom_range(0, 23) == 0);
               r.forced = 1'($urandom_range(0, 29) == 0);
               // broken run: jump to fresh values halfway through
               if (kind == 6 && i == run_len / 2) begin
                  base = random_round();
               end
            end else begin
               r = random_round();
            end
            send_round(r, 1'b0, '0);
         end
         left -= run_len;
      end
   endtask

   // ------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Receiver: random stall runs, plus one long hold that backs the block up
   // ------------------------------------------------------------------
   initial begin
      rsp_stall     <= 1'b0;
      rx_calm       = 0;
      rx_stall_left = 0;
      rx_open_left  = 0;
      pressure_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!pressure_done && rounds_accepted >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (PRESSURE_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rx_stall_left > 0) begin
            rsp_stall <= 1'b1;
            rx_stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (rx_open_left > 0) begin
               rx_open_left--;
            end else begin
               rx_stall_left = pick_gap(rx_calm);
               rx_open_left  = $urandom_range(0, 6);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result checker: sample at the falling edge, where outputs are settled
   // ------------------------------------------------------------------
   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         failures++;
      end
   endtask

   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: result item with nothing outstanding", $time);
            failures++;
         end else begin
            oldest_report = pending_reports.pop_front();
            compare_field("avg_battery", oldest_report.battery, rsp_avg_battery);
            compare_field("avg_humidity", oldest_report.humidity, rsp_avg_humidity);
            compare_field("avg_temperature", oldest_report.temperature, rsp_avg_temperature);
            compare_field("clamped_lux", oldest_report.lux, rsp_clamped_lux);
            compare_field("report_lux", oldest_report.rep_lux, rsp_report_lux);
            compare_field("report_temperature", oldest_report.rep_temp,
                          rsp_report_temperature);
            compare_field("report_humidity", oldest_report.rep_humi, rsp_report_humidity);
            compare_field("report_battery", oldest_report.rep_bat, rsp_report_battery);
            compare_field("report_motion", oldest_report.rep_motion, rsp_report_motion);
            results_checked++;
            reports_seen[CH_LUX]    += oldest_report.rep_lux;
            reports_seen[CH_TEMP]   += oldest_report.rep_temp;
            reports_seen[CH_HUMI]   += oldest_report.rep_humi;
            reports_seen[CH_BAT]    += oldest_report.rep_bat;
            reports_seen[CH_MOTION] += oldest_report.rep_motion;
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: end the run if nothing moves on any channel for too long
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_battery_pct    <= '0;
      req_humidity       <= '0;
      req_temperature    <= '0;
      req_lux            <= '0;
      req_motion_changed <= 1'b0;
      req_force_report   <= 1'b0;
      csr_valid          <= 1'b0;
      csr_index          <= sarf_pkg::REG_BATTERY_MIN;
      csr_data           <= '0;
      failures           = 0;
      rounds_accepted    = 0;
      results_checked    = 0;
      settings_applied   = 0;
      quiet_cycles       = 0;
      tx_calm            = 0;
      for (int k = 0; k < 5; k++) begin
         reports_seen[k] = 0;
      end
      reset_filter_state();

      // hold reset, then release
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rounds at the reset register values
      for (int n = 0; n < DIRECTED_ROWS; n++) begin
         send_round(directed_rows[n].stim, directed_rows[n].typed, directed_rows[n].want);
      end

      // random phases, each under its own register setting
      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle();
         program_setting(setting_for(p));
         run_random(PHASE_ROUNDS);
      end

      // drain and allow for stray extra results
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d rounds (%0d directed) under %0d register settings; %0d results checked.",
               rounds_accepted, DIRECTED_ROWS, settings_applied, results_checked);
      $display("Reports raised: lux %0d, temperature %0d, humidity %0d, battery %0d, motion %0d.",
               reports_seen[CH_LUX], reports_seen[CH_TEMP], reports_seen[CH_HUMI],
               reports_seen[CH_BAT], reports_seen[CH_MOTION]);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
